// ===== rtl/eelt_pkg.sv =====
// ----------------------------------------------------------------------------
// eelt_pkg
// Shared constants, codes and types of the emergency error list tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package eelt_pkg;

    localparam int MONITORED_SLOTS = 4;
    localparam int ERRORS_PER_NODE = 8;
    localparam int CNT_W           = $clog2(ERRORS_PER_NODE + 1);

    localparam int CFG_REGS        = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int NODE_ID_W       = 7;
    localparam int FRAME_ID_W      = 11;
    localparam int FRAME_LEN_W     = 4;
    localparam int SLOT_W          = 2;
    localparam int EV_W            = 2;
    localparam int OUT_CNT_W       = 4;

    localparam logic [FRAME_ID_W-1:0]  EMCY_BASE_ID  = 11'h080;
    localparam logic [FRAME_LEN_W-1:0] ACCEPT_LENGTH = 4'd8;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [EV_W-1:0] EV_ADDED     = 2'd0;
    localparam logic [EV_W-1:0] EV_CLEARED   = 2'd1;
    localparam logic [EV_W-1:0] EV_UNMATCHED = 2'd2;
    localparam logic [EV_W-1:0] EV_FULL      = 2'd3;

    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  err_reg;
        logic [7:0]  fault_bit;
        logic [7:0]  info;
    } t_entry;

    typedef struct packed {
        logic occ;
        logic wr;
        logic remove;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic apply;
    } t_list_ctl;

    typedef struct packed {
        logic [EV_W-1:0]      ev;
        logic [OUT_CNT_W-1:0] count;
    } t_list_status;

endpackage

`default_nettype wire

// ===== rtl/eelt_cell.sv =====
// ----------------------------------------------------------------------------
// eelt_cell
// One error list entry; matches on fault bit and info byte and closes up from its right-hand
// neighbour once a match has been seen at or before it.
// ----------------------------------------------------------------------------
`default_nettype none

module eelt_cell (
    input  wire                      i_clk,
    input  wire eelt_pkg::t_cell_ctl i_ctl,
    input  wire eelt_pkg::t_entry    i_msg,
    input  wire eelt_pkg::t_entry    i_right,
    input  wire                      i_found,
    output eelt_pkg::t_entry         o_entry,
    output logic                     o_found
);
    import eelt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;

    assign w_match = i_ctl.occ && (r_entry.fault_bit == i_msg.fault_bit)
                     && (r_entry.info == i_msg.info);
    assign o_found = i_found | w_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.wr) begin
            n_entry = i_msg;
        end else if (i_ctl.remove && o_found) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/eelt_list.sv =====
// ----------------------------------------------------------------------------
// eelt_list
// Error list of one monitored slot: a row of entry cells and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module eelt_list (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire eelt_pkg::t_list_ctl    i_ctl,
    input  wire eelt_pkg::t_entry       i_msg,
    output eelt_pkg::t_list_status      o_status
);
    import eelt_pkg::*;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   w_add;
    logic                   w_full;
    logic [ERRORS_PER_NODE:0] w_found;
    t_entry                 w_entry [ERRORS_PER_NODE];
    t_entry                 w_right [ERRORS_PER_NODE];
    t_cell_ctl              w_ctl   [ERRORS_PER_NODE];

    assign w_add      = (i_msg.code != 16'd0);
    assign w_full     = (r_count >= CNT_W'(ERRORS_PER_NODE));
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < ERRORS_PER_NODE; g++) begin : g_cell
        assign w_ctl[g].occ    = (r_count > CNT_W'(g));
        assign w_ctl[g].wr     = i_ctl.apply && w_add && !w_full
                                 && (r_count == CNT_W'(g));
        assign w_ctl[g].remove = i_ctl.apply && !w_add;

        if (g == ERRORS_PER_NODE - 1) begin : g_tail
            assign w_right[g] = w_entry[g];
        end else begin : g_body
            assign w_right[g] = w_entry[g+1];
        end

        eelt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_msg   (i_msg),
            .i_right (w_right[g]),
            .i_found (w_found[g]),
            .o_entry (w_entry[g]),
            .o_found (w_found[g+1])
        );
    end

    always_comb begin
        n_count     = r_count;
        o_status.ev = EV_UNMATCHED;
        if (w_add) begin
            o_status.ev = w_full ? EV_FULL : EV_ADDED;
        end else if (w_found[ERRORS_PER_NODE]) begin
            o_status.ev = EV_CLEARED;
        end
        priority if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.apply) begin
            if (w_add && !w_full) begin
                n_count = r_count + CNT_W'(1);
            end else if (!w_add && w_found[ERRORS_PER_NODE]) begin
                n_count = r_count - CNT_W'(1);
            end
        end
        o_status.count = OUT_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/emergency_error_list_tracker.sv =====
// ----------------------------------------------------------------------------
// emergency_error_list_tracker
// Latches emergency frames per monitored slot and, on a process tick, applies
// the pending messages in slot order to each slot's error list.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   start, busy                i_cmd .. i_net_active
//  result    o_result_valid (strobe)    o_slot .. o_last
//  config    i_cfg_wr_en                i_cfg_idx, i_cfg_wdata
//
//  A frame is taken and gives no result.
//  A tick with the network active walks the slots holding a pending message,
//  one slot per cycle through the list update, one result per slot (up to
//  four); busy stays high until the last slot has been applied.
//  Each result sits on the outputs in the cycle after its slot is applied; the
//  receiver cannot stall. Synchronous reset clears ids, pending flags, counts.
// ----------------------------------------------------------------------------
`default_nettype none

module emergency_error_list_tracker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_cmd,
    input  wire  [eelt_pkg::FRAME_ID_W-1:0]  i_frame_id,
    input  wire  [eelt_pkg::FRAME_LEN_W-1:0] i_frame_length,
    input  wire  [15:0]                      i_fault_code,
    input  wire  [7:0]                       i_fault_register,
    input  wire  [7:0]                       i_fault_bit,
    input  wire  [7:0]                       i_info_byte,
    input  wire                              i_net_active,
    input  wire                              i_cfg_wr_en,
    input  wire  [eelt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [eelt_pkg::NODE_ID_W-1:0]   i_cfg_wdata,
    output logic                             o_result_valid,
    output logic [eelt_pkg::SLOT_W-1:0]      o_slot,
    output logic [eelt_pkg::EV_W-1:0]        o_event_res,
    output logic [15:0]                      o_reported_code,
    output logic [eelt_pkg::OUT_CNT_W-1:0]   o_active_count,
    output logic                             o_last
);
    import eelt_pkg::*;

    logic [NODE_ID_W-1:0]       r_node_id [MONITORED_SLOTS];
    logic [MONITORED_SLOTS-1:0] r_pend_valid;
    t_entry                     r_pend_msg [MONITORED_SLOTS];
    logic [MONITORED_SLOTS-1:0] r_mask;
    logic [MONITORED_SLOTS-1:0] n_mask;
    logic [MONITORED_SLOTS-1:0] w_cur_oh;
    logic [MONITORED_SLOTS-1:0] w_hit;
    logic [MONITORED_SLOTS-1:0] w_eligible;
    logic [SLOT_W-1:0]          w_cur;
    logic                       w_accept;
    logic                       w_frame_ok;
    logic                       w_tick;
    t_entry                     w_frame_msg;
    t_entry                     w_cur_msg;
    t_list_ctl                  w_lctl [MONITORED_SLOTS];
    t_list_status               w_lstat [MONITORED_SLOTS];

    assign busy       = |r_mask;
    assign w_accept   = start && !busy;
    assign w_frame_ok = w_accept && (i_cmd == CMD_FRAME)
                        && (i_frame_length == ACCEPT_LENGTH);
    assign w_tick     = w_accept && (i_cmd == CMD_TICK) && i_net_active;

    assign w_frame_msg.code      = i_fault_code;
    assign w_frame_msg.err_reg   = i_fault_register;
    assign w_frame_msg.fault_bit = i_fault_bit;
    assign w_frame_msg.info      = i_info_byte;

    // lowest remaining slot of this tick
    always_comb begin
        w_cur    = '0;
        w_cur_oh = '0;
        for (int s = MONITORED_SLOTS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                w_cur    = SLOT_W'(s);
                w_cur_oh = '0;
                w_cur_oh[s] = 1'b1;
            end
        end
    end

    assign w_cur_msg = r_pend_msg[w_cur];
    assign n_mask    = w_tick ? w_eligible : (r_mask & ~w_cur_oh);

    for (genvar g = 0; g < MONITORED_SLOTS; g++) begin : g_slot
        assign w_hit[g] = (r_node_id[g] != '0)
                          && (i_frame_id == EMCY_BASE_ID + FRAME_ID_W'(r_node_id[g]));
        assign w_eligible[g] = (r_node_id[g] != '0) && r_pend_valid[g];

        assign w_lctl[g].clear = i_cfg_wr_en && (i_cfg_idx == CFG_IDX_W'(g));
        assign w_lctl[g].apply = w_cur_oh[g];

        eelt_list u_list (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_lctl[g]),
            .i_msg    (w_cur_msg),
            .o_status (w_lstat[g])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_node_id[g]    <= '0;
                r_pend_valid[g] <= 1'b0;
            end else begin
                if (w_lctl[g].clear) begin
                    r_node_id[g] <= i_cfg_wdata;
                end
                if (w_frame_ok && w_hit[g]) begin
                    r_pend_valid[g] <= 1'b1;
                end else if (w_cur_oh[g]) begin
                    r_pend_valid[g] <= 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_frame_ok && w_hit[g]) begin
                r_pend_msg[g] <= w_frame_msg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_mask         <= n_mask;
            o_result_valid <= busy;
        end
    end

    always_ff @(posedge i_clk) begin
        o_slot          <= w_cur;
        o_event_res     <= w_lstat[w_cur].ev;
        o_reported_code <= w_cur_msg.code;
        o_active_count  <= w_lstat[w_cur].count;
        o_last          <= ((r_mask & ~w_cur_oh) == '0);
    end

endmodule

`default_nettype wire
